// ----- sv/sqw_pkg.sv -----
// ---------------------------------------------------------------------------
// sqw_pkg: shared definitions for the square-wave sound channel
// Operation codes, lookup tables and the request/response structs that pass
// between the channel top level and its state core.
// ---------------------------------------------------------------------------
package sqw_pkg;

	// Operation codes carried by each input beat
	typedef enum logic [2:0] {
		OP_DUTY_ENV      = 3'd0,
		OP_SWEEP         = 3'd1,
		OP_PERIOD_LO     = 3'd2,
		OP_LENGTH_HI     = 3'd3,
		OP_ENABLE        = 3'd4,
		OP_HALF_FRAME    = 3'd5,
		OP_QUARTER_FRAME = 3'd6,
		OP_TICK          = 3'd7
	} opcode_t;

	localparam int OPCODE_W  = 3;
	localparam int DATA_W    = 8;
	localparam int SAMPLE_W  = 4;
	localparam int PERIOD_W  = 13;

	localparam int LENGTH_ENTRIES = 32;
	localparam int LENGTH_IDX_W   = $clog2(LENGTH_ENTRIES);

	// Usable range of the doubled timer period
	localparam logic [PERIOD_W-1:0] PERIOD_MIN = 13'd8;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 13'h7FF;

	localparam logic [SAMPLE_W-1:0] VOLUME_FULL = 4'd15;

	// Length counter load values
	localparam logic [7:0] LENGTH_TABLE [LENGTH_ENTRIES] = '{
		8'd10,  8'd254, 8'd20,  8'd2,   8'd40,  8'd4,   8'd80,  8'd6,
		8'd160, 8'd8,   8'd60,  8'd10,  8'd14,  8'd12,  8'd26,  8'd14,
		8'd12,  8'd16,  8'd24,  8'd18,  8'd48,  8'd20,  8'd96,  8'd22,
		8'd192, 8'd24,  8'd72,  8'd26,  8'd16,  8'd28,  8'd32,  8'd30
	};

	// Eight-step duty sequences
	localparam logic [7:0] DUTY_TABLE [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

	// One item on its way into the core
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [DATA_W-1:0]   data;
	} step_req_t;

	// What the core returns for that item
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                length_active;
	} step_res_t;

endpackage

// ----- sv/sqw_chan_if.sv -----
// ---------------------------------------------------------------------------
// sqw channel interfaces
// Valid/ready channels for input items, result items and the configuration
// write of the square-wave sound channel.
// ---------------------------------------------------------------------------
interface sqw_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] data;

	modport source (output valid, output opcode, output data, input ready);
	modport sink (input valid, input opcode, input data, output ready);
endinterface

interface sqw_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] sample;
	logic       length_active;

	modport source (output valid, output sample, output length_active, input ready);
	modport sink (input valid, input sample, input length_active, output ready);
endinterface

interface sqw_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/square_wave_sound_channel.sv -----
// ---------------------------------------------------------------------------
// square_wave_sound_channel: pulse sound channel, top level
// Input register, state core and result register of the channel.
// ---------------------------------------------------------------------------
// Usage:
//   item   - one beat per operation (opcode, data): register writes, length
//            enable, half-frame, quarter-frame and timer tick.
//   result - one beat per item: sample (non-zero only on a tick) and the
//            length-active status after that item.
//   cfg    - write of the second-channel sweep select; write it only while
//            no item is in flight. Always ready.
// Timing: an accepted item is held in the input register, processed there
//   by the core, and its result is registered in the result register and
//   offered from there. Throughput is one item per cycle while results are
//   taken; the core commits its state update as each item moves on.
// Reset: all channel state, the sweep select and the valid flags of both
//   pipeline registers clear; no results are pending.
// Stall: while the result beat waits, the input register holds one more
//   item; after that item ready drops until the result is taken.
// ---------------------------------------------------------------------------
module square_wave_sound_channel (
	input  logic                clk,
	input  logic                arst_n,
	sqw_item_if.sink            item,
	sqw_result_if.source        result,
	sqw_cfg_if.sink             cfg
);

	logic               valid_s1;
	sqw_pkg::step_req_t req_s1;
	logic               valid_s2;
	sqw_pkg::step_res_t res_s2;
	sqw_pkg::step_res_t core_res;
	logic               second_q;
	logic               advance;
	logic               item_ready;

	// Move the held item on when the result register is free or emptying
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item_ready = !valid_s1 || advance;
	assign item.ready = item_ready;
	assign cfg.ready  = 1'b1;

	// Hold the sweep negate select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (cfg.valid) begin
			second_q <= cfg.data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item.valid) begin
			req_s1.opcode <= item.opcode;
			req_s1.data   <= item.data;
		end
	end

	sqw_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_s1),
		.fire           (advance),
		.second_channel (second_q),
		.res            (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= core_res;
		end
	end

	assign result.valid         = valid_s2;
	assign result.sample        = res_s2.sample;
	assign result.length_active = res_s2.length_active;

	// A channel with no length left never sounds
	a_silent_when_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.length_active) |-> (res_s2.sample == '0))
		else $error("sample non-zero while length counter is empty");

	// Ready drops only when both registers are full and the result stalls
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("input stalled without a full, stalled pipeline");

	// Every processed item yields a result beat on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed item produced no result beat");

endmodule

// ----- sv/sqw_core.sv -----
// ---------------------------------------------------------------------------
// sqw_core: channel state and combinational step logic
// Holds envelope, sweep, length, timer and sequencer state; works out the
// result of the presented item and commits the new state when fired.
// ---------------------------------------------------------------------------
module sqw_core (
	input  logic              clk,
	input  logic              arst_n,
	input  sqw_pkg::step_req_t req,
	input  logic              fire,
	input  logic              second_channel,
	output sqw_pkg::step_res_t res
);

	localparam int PW = sqw_pkg::PERIOD_W;

	logic [7:0]    duty_pattern_q, duty_pattern_d;
	logic          loop_or_halt_q, loop_or_halt_d;
	logic          envelope_mode_q, envelope_mode_d;
	logic [3:0]    envelope_period_q, envelope_period_d;
	logic          sweep_active_q, sweep_active_d;
	logic          sweep_negate_q, sweep_negate_d;
	logic [2:0]    sweep_amount_q, sweep_amount_d;
	logic [2:0]    sweep_interval_q, sweep_interval_d;
	logic          sweep_reload_q, sweep_reload_d;
	logic [3:0]    sweep_count_q, sweep_count_d;
	logic [3:0]    env_count_q, env_count_d;
	logic          env_restart_q, env_restart_d;
	logic [3:0]    volume_q, volume_d;
	logic [7:0]    length_q, length_d;
	logic          length_en_q, length_en_d;
	logic [PW-1:0] period_q, period_d;
	logic [PW-1:0] timer_q, timer_d;
	logic [2:0]    step_q, step_d;
	logic          out_bit_q, out_bit_d;

	logic          period_ok;
	logic [PW-1:0] sweep_delta;
	logic [PW-1:0] period_sub;
	logic [PW-1:0] period_add;
	logic [3:0]    sample;

	assign period_ok   = (period_q >= sqw_pkg::PERIOD_MIN) && (period_q <= sqw_pkg::PERIOD_MAX);
	assign sweep_delta = period_q >> sweep_amount_q;
	assign period_sub  = period_q - sweep_delta - {{(PW-1){1'b0}}, second_channel};
	assign period_add  = period_q + sweep_delta;

	// Work out next state and the sample for the presented item
	always_comb begin
		duty_pattern_d    = duty_pattern_q;
		loop_or_halt_d    = loop_or_halt_q;
		envelope_mode_d   = envelope_mode_q;
		envelope_period_d = envelope_period_q;
		sweep_active_d    = sweep_active_q;
		sweep_negate_d    = sweep_negate_q;
		sweep_amount_d    = sweep_amount_q;
		sweep_interval_d  = sweep_interval_q;
		sweep_reload_d    = sweep_reload_q;
		sweep_count_d     = sweep_count_q;
		env_count_d       = env_count_q;
		env_restart_d     = env_restart_q;
		volume_d          = volume_q;
		length_d          = length_q;
		length_en_d       = length_en_q;
		period_d          = period_q;
		timer_d           = timer_q;
		step_d            = step_q;
		out_bit_d         = out_bit_q;
		sample            = '0;

		case (sqw_pkg::opcode_t'(req.opcode))
			sqw_pkg::OP_DUTY_ENV: begin
				loop_or_halt_d    = req.data[5];
				envelope_mode_d   = ~req.data[4];
				duty_pattern_d    = sqw_pkg::DUTY_TABLE[req.data[7:6]];
				envelope_period_d = req.data[3:0];
			end
			sqw_pkg::OP_SWEEP: begin
				sweep_active_d   = req.data[7];
				sweep_negate_d   = req.data[3];
				sweep_amount_d   = req.data[2:0];
				sweep_interval_d = req.data[6:4];
				sweep_reload_d   = 1'b1;
			end
			sqw_pkg::OP_PERIOD_LO: begin
				period_d = {1'b0, period_q[11:9], req.data, 1'b0};
			end
			sqw_pkg::OP_LENGTH_HI: begin
				if (length_en_q) begin
					length_d = sqw_pkg::LENGTH_TABLE[req.data[7:3]];
				end
				period_d      = {1'b0, req.data[2:0], period_q[8:1], 1'b0};
				timer_d       = {1'b0, req.data[2:0], period_q[8:1], 1'b0};
				step_d        = '0;
				env_restart_d = 1'b1;
			end
			sqw_pkg::OP_ENABLE: begin
				length_en_d = req.data[0];
				if (!req.data[0]) begin
					length_d = '0;
				end
			end
			sqw_pkg::OP_HALF_FRAME: begin
				// count down length unless halted
				if (!loop_or_halt_q && (length_q != '0)) begin
					length_d = length_q - 8'd1;
				end
				// sweep divider and period update
				if (sweep_active_q) begin
					if (sweep_count_q == '0) begin
						sweep_count_d = {1'b0, sweep_interval_q};
						if (period_ok) begin
							period_d = sweep_negate_q ? period_sub : period_add;
						end
					end else begin
						sweep_count_d = sweep_count_q - 4'd1;
					end
				end
				if (sweep_reload_q) begin
					sweep_count_d  = {1'b0, sweep_interval_q};
					sweep_reload_d = 1'b0;
				end
			end
			sqw_pkg::OP_QUARTER_FRAME: begin
				// envelope runs only in decaying mode
				if (envelope_mode_q) begin
					if (env_restart_q) begin
						volume_d      = sqw_pkg::VOLUME_FULL;
						env_count_d   = envelope_period_q;
						env_restart_d = 1'b0;
					end else if (env_count_q == '0) begin
						if (volume_q == '0) begin
							volume_d = loop_or_halt_q ? sqw_pkg::VOLUME_FULL : 4'd0;
						end else begin
							volume_d = volume_q - 4'd1;
						end
						env_count_d = envelope_period_q;
					end else begin
						env_count_d = env_count_q - 4'd1;
					end
				end
			end
			default: begin
				// timer tick: silent and frozen when muted
				if ((length_q != '0) && period_ok) begin
					if (timer_q == '0) begin
						out_bit_d = duty_pattern_q[step_q];
						step_d    = step_q + 3'd1;
						timer_d   = period_q;
					end else begin
						timer_d = timer_q - {{(PW-1){1'b0}}, 1'b1};
					end
					if (out_bit_d) begin
						sample = envelope_mode_q ? volume_q : envelope_period_q;
					end
				end
			end
		endcase
	end

	assign res.sample        = sample;
	assign res.length_active = (length_d != '0);

	// Commit state on each fired item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_pattern_q    <= '0;
			loop_or_halt_q    <= 1'b0;
			envelope_mode_q   <= 1'b0;
			envelope_period_q <= '0;
			sweep_active_q    <= 1'b0;
			sweep_negate_q    <= 1'b0;
			sweep_amount_q    <= '0;
			sweep_interval_q  <= '0;
			sweep_reload_q    <= 1'b0;
			sweep_count_q     <= '0;
			env_count_q       <= '0;
			env_restart_q     <= 1'b0;
			volume_q          <= '0;
			length_q          <= '0;
			length_en_q       <= 1'b0;
			period_q          <= '0;
			timer_q           <= '0;
			step_q            <= '0;
			out_bit_q         <= 1'b0;
		end else if (fire) begin
			duty_pattern_q    <= duty_pattern_d;
			loop_or_halt_q    <= loop_or_halt_d;
			envelope_mode_q   <= envelope_mode_d;
			envelope_period_q <= envelope_period_d;
			sweep_active_q    <= sweep_active_d;
			sweep_negate_q    <= sweep_negate_d;
			sweep_amount_q    <= sweep_amount_d;
			sweep_interval_q  <= sweep_interval_d;
			sweep_reload_q    <= sweep_reload_d;
			sweep_count_q     <= sweep_count_d;
			env_count_q       <= env_count_d;
			env_restart_q     <= env_restart_d;
			volume_q          <= volume_d;
			length_q          <= length_d;
			length_en_q       <= length_en_d;
			period_q          <= period_d;
			timer_q           <= timer_d;
			step_q            <= step_d;
			out_bit_q         <= out_bit_d;
		end
	end

endmodule
